FILE: src/stereo_gated_level_mean_macros.svh
// assertion macros shared by the checker of the stereo level meter
`ifndef STEREO_GATED_LEVEL_MEAN_MACROS_SVH
`define STEREO_GATED_LEVEL_MEAN_MACROS_SVH

// condition implies consequence in the same cycle
`define SGLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define SGLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sglm_pkg.sv
// types and constants of the stereo gated level meter
package sglm_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int THR_BITS      = 12;
    localparam int OFF_BITS      = 12;
    localparam int LIMIT_BITS    = 14;
    localparam int SUM_BITS      = SAMPLE_BITS + 14;
    localparam int DIV_BITS      = 15;
    localparam int COUNT_BITS    = 15;
    localparam int STEP_BITS     = $clog2(SUM_BITS);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 14;
    localparam int QUEUE_DEPTH   = 2;
    localparam int PTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS     = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_GATE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_LEVEL_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WINDOW_LIMIT   = 2'd2;

    // register reset values
    localparam logic [THR_BITS-1:0]   GATE_THRESHOLD_RST = 12'd1920;
    localparam logic [OFF_BITS-1:0]   LEVEL_OFFSET_RST   = 12'd1919;
    localparam logic [LIMIT_BITS-1:0] WINDOW_LIMIT_RST   = 14'd10000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_mean;
        logic [SAMPLE_BITS-1:0] right_mean;
        logic                   left_updated;
        logic                   right_updated;
        logic                   window_restarted;
    } t_out_item;

    typedef struct packed {
        logic [THR_BITS-1:0]   gate_threshold;
        logic [OFF_BITS-1:0]   level_offset;
        logic [LIMIT_BITS-1:0] window_limit;
    } t_cfg;

    // classified item passed from front to back
    typedef struct packed {
        logic                   left_pass;
        logic [SAMPLE_BITS-1:0] left_part;
        logic                   right_pass;
        logic [SAMPLE_BITS-1:0] right_part;
        logic                   restart;
    } t_job;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_back_state;

endpackage

FILE: src/sglm_queue.sv
// two-entry queue of classified items between front and back
module sglm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sglm_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_pop,
    output sglm_pkg::t_job o_job
);
    import sglm_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [FILL_BITS-1:0] r_fill;

    assign o_ready = (r_fill != FILL_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_job   = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

FILE: src/sglm_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module sglm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [sglm_pkg::SUM_BITS-1:0]    i_dividend,
    input  logic [sglm_pkg::DIV_BITS-1:0]    i_divisor,
    output logic                             o_busy,
    output logic [sglm_pkg::SAMPLE_BITS-1:0] o_quotient
);
    import sglm_pkg::*;

    logic                  r_busy;
    logic [STEP_BITS-1:0]  r_cnt;
    logic [DIV_BITS-1:0]   r_rem;
    logic [SUM_BITS-1:0]   r_quo;
    logic [DIV_BITS-1:0]   r_den;
    logic [DIV_BITS:0]     w_rem_sh;
    logic [DIV_BITS+1:0]   w_diff;
    logic                  w_ge;
    logic [DIV_BITS-1:0]   w_rem_next;

    // trial subtraction of the shifted remainder
    always_comb begin
        w_rem_sh   = {r_rem, r_quo[SUM_BITS-1]};
        w_diff     = {1'b0, w_rem_sh} - {2'b00, r_den};
        w_ge       = !w_diff[DIV_BITS+1];
        w_rem_next = w_ge ? w_diff[DIV_BITS-1:0] : w_rem_sh[DIV_BITS-1:0];
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo[SAMPLE_BITS-1:0];

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_BITS'(SUM_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[SUM_BITS-2:0], w_ge};
        end
    end

endmodule

FILE: src/sglm_front.sv
// front end: gates samples, removes offset and keeps the window count
module sglm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sglm_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  sglm_pkg::t_in_item i_item,
    output logic               o_ready,
    input  logic               i_q_ready,
    output logic               o_push,
    output sglm_pkg::t_job     o_job
);
    import sglm_pkg::*;

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] w_count_inc;
    logic                  w_restart;

    // window count and restart decision
    always_comb begin
        w_count_inc = r_count + 1'b1;
        w_restart   = (w_count_inc > COUNT_BITS'(i_cfg.window_limit));
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    // classify both channels
    always_comb begin
        o_job.left_pass  = (i_item.left_sample > i_cfg.gate_threshold);
        o_job.right_pass = (i_item.right_sample > i_cfg.gate_threshold);
        o_job.left_part  = (i_item.left_sample > i_cfg.level_offset)
                         ? i_item.left_sample - i_cfg.level_offset : '0;
        o_job.right_part = (i_item.right_sample > i_cfg.level_offset)
                         ? i_item.right_sample - i_cfg.level_offset : '0;
        o_job.restart    = w_restart;
    end

    // items in the current window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= w_restart ? '0 : w_count_inc;
        end
    end

endmodule

FILE: src/sglm_back.sv
// back end: accumulates, divides both channels and holds the result
module sglm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  sglm_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output sglm_pkg::t_out_item o_item
);
    import sglm_pkg::*;

    t_back_state             r_state;
    t_back_state             n_state;
    t_job                    r_job;
    t_out_item               r_out;
    logic                    r_out_valid;
    logic [SUM_BITS-1:0]     r_lsum;
    logic [SUM_BITS-1:0]     r_rsum;
    logic [DIV_BITS-1:0]     r_ldiv;
    logic [DIV_BITS-1:0]     r_rdiv;
    logic [SAMPLE_BITS-1:0]  r_lmean;
    logic [SAMPLE_BITS-1:0]  r_rmean;
    logic [SUM_BITS-1:0]     w_lsum_new;
    logic [SUM_BITS-1:0]     w_rsum_new;
    logic [DIV_BITS-1:0]     w_lden;
    logic [DIV_BITS-1:0]     w_rden;
    logic                    w_start;
    logic                    w_finish;
    logic                    w_lbusy;
    logic                    w_rbusy;
    logic [SAMPLE_BITS-1:0]  w_lquo;
    logic [SAMPLE_BITS-1:0]  w_rquo;
    logic [SAMPLE_BITS-1:0]  w_lmean;
    logic [SAMPLE_BITS-1:0]  w_rmean;

    // new sums and guarded divisors for the head item
    always_comb begin
        w_lsum_new = r_lsum + (i_job.left_pass ? SUM_BITS'(i_job.left_part) : '0);
        w_rsum_new = r_rsum + (i_job.right_pass ? SUM_BITS'(i_job.right_part) : '0);
        w_lden     = (r_ldiv == '0) ? DIV_BITS'(1) : r_ldiv;
        w_rden     = (r_rdiv == '0) ? DIV_BITS'(1) : r_rdiv;
        w_lmean    = r_job.left_pass ? w_lquo : r_lmean;
        w_rmean    = r_job.right_pass ? w_rquo : r_rmean;
    end

    sglm_div u_ldiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_lsum_new),
        .i_divisor  (w_lden),
        .o_busy     (w_lbusy),
        .o_quotient (w_lquo)
    );

    sglm_div u_rdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_rsum_new),
        .i_divisor  (w_rden),
        .o_busy     (w_rbusy),
        .o_quotient (w_rquo)
    );

    // next state and control
    always_comb begin
        n_state  = r_state;
        w_start  = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    w_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!w_lbusy && !w_rbusy && (!r_out_valid || i_ready)) begin
                    w_finish = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_pop   = w_start;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // channel state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsum      <= '0;
            r_rsum      <= '0;
            r_ldiv      <= DIV_BITS'(1);
            r_rdiv      <= DIV_BITS'(1);
            r_lmean     <= '0;
            r_rmean     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_start) begin
                r_lsum <= w_lsum_new;
                r_rsum <= w_rsum_new;
            end
            if (w_finish) begin
                r_lmean     <= w_lmean;
                r_rmean     <= w_rmean;
                r_out_valid <= 1'b1;
                if (r_job.restart) begin
                    r_lsum <= '0;
                    r_rsum <= '0;
                    r_ldiv <= DIV_BITS'(1);
                    r_rdiv <= DIV_BITS'(1);
                end else begin
                    if (r_job.left_pass) begin
                        r_ldiv <= r_ldiv + 1'b1;
                    end
                    if (r_job.right_pass) begin
                        r_rdiv <= r_rdiv + 1'b1;
                    end
                end
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job and result payload
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_job <= i_job;
        end
        if (w_finish) begin
            r_out.left_mean        <= w_lmean;
            r_out.right_mean       <= w_rmean;
            r_out.left_updated     <= r_job.left_pass;
            r_out.right_updated    <= r_job.right_pass;
            r_out.window_restarted <= r_job.restart;
        end
    end

endmodule

FILE: src/stereo_gated_level_mean.sv
// top level of the stereo gated level meter
// Each transaction carries one left and one right sample and yields one result with both
// held means, two gate flags and a window restart flag. A sample above gate_threshold has
// level_offset removed (floored at zero) and is summed; the channel mean is the sum divided
// by the number of gated samples so far in the window, and a channel without a gated sample
// keeps its last mean. In the back end an item is loaded, passes the bit-serial dividers (one
// quotient bit per bit of the 26-bit sum, both channels in parallel) and is then written to
// the result register; the back end takes a new item only after the last one is written.
// A two-entry queue lets the front accept items while the back divides, and the result
// register holds a finished item while the next one is already being divided. Configuration
// registers are written through a plain write port and should change only while idle.
module stereo_gated_level_mean (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  sglm_pkg::t_in_item                 i_item,
    output logic                               o_valid,
    input  logic                               i_ready,
    output sglm_pkg::t_out_item                o_item,
    input  logic                               i_cfg_we,
    input  logic [sglm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [sglm_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import sglm_pkg::*;

    t_cfg r_cfg;
    t_job w_front_job;
    t_job w_queue_job;
    logic w_push;
    logic w_q_ready;
    logic w_q_valid;
    logic w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_threshold <= GATE_THRESHOLD_RST;
            r_cfg.level_offset   <= LEVEL_OFFSET_RST;
            r_cfg.window_limit   <= WINDOW_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_GATE_THRESHOLD: r_cfg.gate_threshold <= i_cfg_data[THR_BITS-1:0];
                CFG_IDX_LEVEL_OFFSET:   r_cfg.level_offset   <= i_cfg_data[OFF_BITS-1:0];
                CFG_IDX_WINDOW_LIMIT:   r_cfg.window_limit   <= i_cfg_data[LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    sglm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .i_item    (i_item),
        .o_ready   (o_ready),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_job     (w_front_job)
    );

    sglm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_queue_job)
    );

    sglm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_queue_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

FILE: src/sglm_checker.sv
// port-level checker of the stereo level meter and its bind
`include "stereo_gated_level_mean_macros.svh"

module sglm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input sglm_pkg::t_out_item i_out_item
);
    import sglm_pkg::*;

    logic [2:0]             r_outstanding;
    logic [SAMPLE_BITS-1:0] r_last_left;
    logic [SAMPLE_BITS-1:0] r_last_right;
    logic                   w_in_acc;
    logic                   w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // transactions in flight and last delivered means
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
            r_last_left   <= '0;
            r_last_right  <= '0;
        end else begin
            if (w_in_acc && !w_out_acc) begin
                r_outstanding <= r_outstanding + 1'b1;
            end else if (!w_in_acc && w_out_acc) begin
                r_outstanding <= r_outstanding - 1'b1;
            end
            if (w_out_acc) begin
                r_last_left  <= i_out_item.left_mean;
                r_last_right <= i_out_item.right_mean;
            end
        end
    end

    // a stalled result holds
    `SGLM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_item), "result changed while stalled")

    // every result belongs to an accepted transaction
    `SGLM_ASSERT_NOW(a_no_extra, i_clk, i_rst_n, i_out_valid,
        r_outstanding != 3'd0, "result without an accepted transaction")

    // a channel without a gated sample repeats its last mean
    `SGLM_ASSERT_NOW(a_left_hold, i_clk, i_rst_n, i_out_valid && !i_out_item.left_updated,
        i_out_item.left_mean == r_last_left, "left mean moved without update")

    `SGLM_ASSERT_NOW(a_right_hold, i_clk, i_rst_n, i_out_valid && !i_out_item.right_updated,
        i_out_item.right_mean == r_last_right, "right mean moved without update")

endmodule

bind stereo_gated_level_mean sglm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_item  (o_item)
);
